FILE: rtl/core/stg_pkg.sv
// stg_pkg: shared types, constants and table-build functions for the sine tone generator.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package stg_pkg;

    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SINE_BITS_DEF       = 16;

    localparam int PHASE_BITS  = 32;
    localparam int AMP_BITS    = 23;
    localparam int SAMPLE_BITS = 24;
    localparam int SLOT_BITS   = 32;
    localparam int TOP_ALIGN   = SLOT_BITS - SAMPLE_BITS;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE  = 1'd1;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = 32'd89478485; // 1 kHz at 48 kHz
    localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET  = 23'd3355443;  // 0.4 full scale

    // pi/2 in Q.60
    localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1847;

    // Advance strobes for the scale stages
    typedef struct packed {
        logic load_mul;
        logic load_out;
    } stg_adv_t;

    // Q.60 product with optional round, 64-bit throughout
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b,
                                            input logic rnd);
        logic [63:0] a0, a1, b0, b1;
        logic [63:0] p00, p01, p10, p11;
        logic [63:0] mid, lo, hi, lo2;
        a0  = {32'd0, a[31:0]};
        a1  = {32'd0, a[63:32]};
        b0  = {32'd0, b[31:0]};
        b1  = {32'd0, b[63:32]};
        p00 = a0 * b0;
        p01 = a0 * b1;
        p10 = a1 * b0;
        p11 = a1 * b1;
        mid = {32'd0, p00[63:32]} + {32'd0, p01[31:0]} + {32'd0, p10[31:0]};
        lo  = {mid[31:0], p00[31:0]};
        hi  = p11 + {32'd0, p01[63:32]} + {32'd0, p10[63:32]} + {32'd0, mid[63:32]};
        if (rnd)
        begin
            lo2 = lo + (64'd1 << 59);
            if (lo2 < lo)
            begin
                hi = hi + 64'd1;
            end
            lo = lo2;
        end
        return (hi << 4) | (lo >> 60);
    endfunction

    // Shift-subtract quotient for the small series divisors; elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo, rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series sine on [0, pi/2], Q.60; elaboration only
    function automatic logic [63:0] sin_q60(input logic [63:0] x);
        logic [63:0] x2, term, sum, divisor;
        x2   = mul_q60(x, x, 1'b0);
        term = x;
        sum  = x;
        for (int n = 1; n <= 15; n++)
        begin
            divisor = 64'((2 * n) * (2 * n + 1));
            term    = div_u64(mul_q60(term, x2, 1'b0), divisor);
            if ((n & 1) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Quarter-wave entry k: sin(pi/2 * (2k+1)/(2N)) scaled to signed Q1.(sine_bits-1)
    function automatic logic [63:0] sine_entry(input int k, input int addr_bits,
                                               input int sine_bits);
        logic [63:0] q, r, odd, x, full;
        q    = Q60_HALF_PI >> (addr_bits + 1);
        r    = Q60_HALF_PI & ((64'd1 << (addr_bits + 1)) - 64'd1);
        odd  = 64'(2 * k + 1);
        x    = q * odd + ((r * odd) >> (addr_bits + 1));
        full = (64'd1 << (sine_bits - 1)) - 64'd1;
        return mul_q60(sin_q60(x), full, 1'b1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/stg_sine_rom.sv
// stg_sine_rom: quarter-wave sine ROM, contents built at elaboration, registered read.
// Depends on stg_pkg (sine_entry).
`default_nettype none

module stg_sine_rom #(
    parameter int TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SINE_BITS       = stg_pkg::SINE_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [TABLE_ADDR_BITS-1:0] addr,
    output logic      [SINE_BITS-2:0]       data
);

    localparam int DEPTH = 2 ** TABLE_ADDR_BITS;

    typedef logic [SINE_BITS-2:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k < DEPTH; k++)
        begin
            t[k] = (SINE_BITS - 1)'(stg_pkg::sine_entry(k, TABLE_ADDR_BITS, SINE_BITS));
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [SINE_BITS-2:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stg_phase_acc.sv
// stg_phase_acc: 32-bit phase accumulator and quarter-wave address fold.
// Depends on stg_pkg.
`default_nettype none

module stg_phase_acc #(
    parameter int TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             step_en,
    input  wire logic [stg_pkg::PHASE_BITS-1:0]   phase_step,
    output logic      [stg_pkg::PHASE_BITS-1:0]   phase,
    output logic      [TABLE_ADDR_BITS-1:0]       rom_addr,
    output logic                                  negate
);

    logic [stg_pkg::PHASE_BITS-1:0] phase_reg;
    logic [stg_pkg::PHASE_BITS-1:0] phase_next;
    logic [1:0]                     quad;
    logic [TABLE_ADDR_BITS-1:0]     k;

    assign phase_next = phase_reg + phase_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
        end
    end

    // Address comes from the updated phase.
    assign quad = phase_next[stg_pkg::PHASE_BITS-1 -: 2];
    assign k    = phase_next[stg_pkg::PHASE_BITS-3 -: TABLE_ADDR_BITS];

    // Odd quadrants run the table backward: N-1-k is ~k.
    assign rom_addr = quad[0] ? ~k : k;
    assign negate   = quad[1];
    assign phase    = phase_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stg_sample_scale.sv
// stg_sample_scale: amplitude multiply, sign and top-align into the output slot.
// Depends on stg_pkg (stg_adv_t, widths).
`default_nettype none

module stg_sample_scale #(
    parameter int SINE_BITS = stg_pkg::SINE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire stg_pkg::stg_adv_t                    adv,
    input  wire logic        [SINE_BITS-2:0]          entry,
    input  wire logic                                 negate,
    input  wire logic        [stg_pkg::AMP_BITS-1:0]  amplitude,
    output logic signed      [stg_pkg::SLOT_BITS-1:0] slot
);

    localparam int PROD_BITS = SINE_BITS - 1 + stg_pkg::AMP_BITS;

    logic [PROD_BITS-1:0]                   product;
    logic [stg_pkg::AMP_BITS-1:0]           mag_reg;
    logic                                   neg_reg;
    logic signed [stg_pkg::SAMPLE_BITS-1:0] sample;
    logic signed [stg_pkg::SLOT_BITS-1:0]   slot_reg;

    assign product = PROD_BITS'(entry) * PROD_BITS'(amplitude);

    // |sample| < amplitude, so the magnitude fits the amplitude width.
    always_ff @(posedge clk)
    begin
        if (adv.load_mul)
        begin
            mag_reg <= stg_pkg::AMP_BITS'(product >> (SINE_BITS - 1));
            neg_reg <= negate;
        end
    end

    assign sample = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    always_ff @(posedge clk)
    begin
        if (adv.load_out)
        begin
            slot_reg <= {sample, {stg_pkg::TOP_ALIGN{1'b0}}};
        end
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sine_tone_generator_top.sv
// sine_tone_generator_top: DDS sine NCO for a test tone, top level.
// Depends on stg_pkg, stg_phase_acc, stg_sine_rom, stg_sample_scale.
//
//  channel  | beat qualifier          | payload                 | direction
//  ---------+-------------------------+-------------------------+----------
//  input    | in_valid & !in_stall    | tick                    | in
//  output   | out_valid & !out_stall  | left_slot, right_slot   | out
//  config   | cfg_we                  | cfg_index, cfg_data     | in
//
// out_valid follows the input beat through the v1, v2 and v3 valid registers; the result
// beat completes when out_stall is low. One beat per cycle sustained while out_stall is low.
// Stages: phase add + ROM read (ROM output register), amplitude multiply, sign/align.
// Each stage moves when the next one is empty or moving, so bubbles collapse and
// in_stall rises only with all three stages full and out_stall high.
// A beat with tick low is consumed with no frame and no phase change.
// rst_n clears the phase and the valid bits and sets the config registers to 1 kHz / 0.4 scale.
`default_nettype none

module sine_tone_generator_top #(
    parameter int TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SINE_BITS       = stg_pkg::SINE_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // input beat
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic                                     tick,
    // result beat
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic signed [stg_pkg::SLOT_BITS-1:0]          left_slot,
    output logic signed [stg_pkg::SLOT_BITS-1:0]          right_slot,
    // config writes
    input  wire logic                                     cfg_we,
    input  wire logic   [stg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic   [stg_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    // ---------------- configuration registers ----------------
    logic [stg_pkg::PHASE_BITS-1:0] phase_step_reg;
    logic [stg_pkg::AMP_BITS-1:0]   amplitude_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= stg_pkg::PHASE_STEP_RESET;
            amplitude_reg  <= stg_pkg::AMPLITUDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stg_pkg::REG_PHASE_STEP:
                begin
                    phase_step_reg <= cfg_data[stg_pkg::PHASE_BITS-1:0];
                end
                stg_pkg::REG_AMPLITUDE:
                begin
                    amplitude_reg <= cfg_data[stg_pkg::AMP_BITS-1:0];
                end
                default:
                begin
                    phase_step_reg <= phase_step_reg;
                end
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic ready1, ready2, ready3;
    logic in_beat;
    logic frame_en;

    assign ready3 = !v3_reg || !out_stall;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign in_stall = !ready1;
    assign in_beat  = in_valid && ready1;
    assign frame_en = in_beat && tick;

    assign v1_next = ready1 ? frame_en : v1_reg;
    assign v2_next = ready2 ? v1_reg   : v2_reg;
    assign v3_next = ready3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ---------------- stage 1: phase and table read ----------------
    logic [stg_pkg::PHASE_BITS-1:0] phase;
    logic [TABLE_ADDR_BITS-1:0]     rom_addr;
    logic                           negate;
    logic                           neg1_reg;
    logic [SINE_BITS-2:0]           entry;

    stg_phase_acc #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (frame_en),
        .phase_step (phase_step_reg),
        .phase      (phase),
        .rom_addr   (rom_addr),
        .negate     (negate)
    );

    stg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SINE_BITS       (SINE_BITS)
    ) u_sine_rom (
        .clk   (clk),
        .rd_en (ready1),
        .addr  (rom_addr),
        .data  (entry)
    );

    // Sign rides alongside the ROM output register.
    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            neg1_reg <= negate;
        end
    end

    // ---------------- stages 2 and 3: scale and align ----------------
    stg_pkg::stg_adv_t              adv;
    logic signed [stg_pkg::SLOT_BITS-1:0] slot;

    assign adv.load_mul = ready2;
    assign adv.load_out = ready3;

    stg_sample_scale #(
        .SINE_BITS (SINE_BITS)
    ) u_sample_scale (
        .clk       (clk),
        .adv       (adv),
        .entry     (entry),
        .negate    (neg1_reg),
        .amplitude (amplitude_reg),
        .slot      (slot)
    );

    assign out_valid  = v3_reg;
    assign left_slot  = slot;
    assign right_slot = slot;

    // ---------------- assertions ----------------
    // Phase moves by exactly one step per frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_en |=> phase == $past(phase) + $past(phase_step_reg))
        else $error("phase did not advance by phase_step");

    // Phase holds when no frame enters.
    assert property (@(posedge clk) disable iff (!rst_n)
        !frame_en |=> phase == $past(phase))
        else $error("phase moved without a frame");

    // Input is held back only when every stage is full and the sink stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // Slot is top-aligned and both channels agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_slot[stg_pkg::TOP_ALIGN-1:0] == '0) && (left_slot == right_slot))
        else $error("output slot malformed");

endmodule

`default_nettype wire
